>>> src/thp_pkg.sv
// Shared types, register map and constants for the two-hand press controller.
package thp_pkg;

    // Phase timer width and its saturation value
    localparam int TIMER_WIDTH = 16;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    // Width used when comparing the timer against a limit register
    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    // Configuration bus geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int INDEX_W = 3;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_WINDOW_TICKS   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_RUN_TICKS      = 3'd1;
    localparam logic [INDEX_W-1:0] REG_RELEASE_TICKS  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_BUZZER_PERIOD  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_ALARM_ON       = 3'd4;
    localparam logic [INDEX_W-1:0] REG_ALARM_CYCLE    = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_WINDOW_TICKS  = 16'd2500;
    localparam logic [15:0] RST_RUN_TICKS     = 16'd50000;
    localparam logic [7:0]  RST_RELEASE_TICKS = 8'd120;
    localparam logic [7:0]  RST_BUZZER_PERIOD = 8'd2;
    localparam logic [11:0] RST_ALARM_ON      = 12'd1000;
    localparam logic [11:0] RST_ALARM_CYCLE   = 12'd2000;

    // Controller phase, also the value reported on the result beat
    typedef enum logic [2:0] {
        PH_WAIT_RELEASE = 3'd0,
        PH_WAIT_PRESS   = 3'd1,
        PH_WINDOW       = 3'd2,
        PH_RUNNING      = 3'd3,
        PH_ALARM        = 3'd4
    } phase_t;

    // Configuration seen by the core
    typedef struct packed {
        logic [15:0] window_ticks;
        logic [15:0] run_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  buzzer_period_ticks;
        logic [11:0] alarm_on_events;
        logic [11:0] alarm_cycle_events;
    } cfg_t;

endpackage

>>> src/thp_cfg_regs.sv
// APB-style configuration register file for the two-hand press controller.
module thp_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [thp_pkg::ADDR_W-1:0] paddr,
    input  logic [thp_pkg::DATA_W-1:0] pwdata,
    output logic [thp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output thp_pkg::cfg_t              cfg
);
    import thp_pkg::*;

    cfg_t               cfg_reg;
    logic [INDEX_W-1:0] index;
    logic               wr_en;

    assign pready = 1'b1;
    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_ticks        <= RST_WINDOW_TICKS;
            cfg_reg.run_ticks           <= RST_RUN_TICKS;
            cfg_reg.release_ticks       <= RST_RELEASE_TICKS;
            cfg_reg.buzzer_period_ticks <= RST_BUZZER_PERIOD;
            cfg_reg.alarm_on_events     <= RST_ALARM_ON;
            cfg_reg.alarm_cycle_events  <= RST_ALARM_CYCLE;
        end else if (wr_en) begin
            unique case (index)
                REG_WINDOW_TICKS:  cfg_reg.window_ticks        <= pwdata[15:0];
                REG_RUN_TICKS:     cfg_reg.run_ticks           <= pwdata[15:0];
                REG_RELEASE_TICKS: cfg_reg.release_ticks       <= pwdata[7:0];
                REG_BUZZER_PERIOD: cfg_reg.buzzer_period_ticks <= pwdata[7:0];
                REG_ALARM_ON:      cfg_reg.alarm_on_events     <= pwdata[11:0];
                REG_ALARM_CYCLE:   cfg_reg.alarm_cycle_events  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (index)
            REG_WINDOW_TICKS:  prdata = DATA_W'(cfg_reg.window_ticks);
            REG_RUN_TICKS:     prdata = DATA_W'(cfg_reg.run_ticks);
            REG_RELEASE_TICKS: prdata = DATA_W'(cfg_reg.release_ticks);
            REG_BUZZER_PERIOD: prdata = DATA_W'(cfg_reg.buzzer_period_ticks);
            REG_ALARM_ON:      prdata = DATA_W'(cfg_reg.alarm_on_events);
            REG_ALARM_CYCLE:   prdata = DATA_W'(cfg_reg.alarm_cycle_events);
            default:           prdata = '0;
        endcase
    end

endmodule

>>> src/thp_core.sv
// Input register, phase logic and result register of the two-hand press controller.
module thp_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  thp_pkg::cfg_t cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [0] first_button, [1] second_button, [2] emergency_button
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata    // [0] motor_on, [1] buzzer_on, [4:2] phase
);
    import thp_pkg::*;

    // Input stage
    logic                   in_valid_reg;
    logic [2:0]             in_btn_reg;
    // Controller state
    phase_t                 phase_reg,  phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg,  timer_next;
    logic [11:0]            events_reg, events_next;
    logic [7:0]             pre_reg,    pre_next;
    logic                   level_reg,  level_next;
    // Result stage
    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;

    logic                   advance;
    logic                   b1, b2, em, any_btn;
    logic [TIMER_WIDTH-1:0] tmr_base, tmr_inc;
    logic [15:0]            limit;
    logic                   expire;
    logic [7:0]             pre_inc;
    logic [11:0]            ev_base;

    // Move the input beat into the result stage when that stage is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign b1      = in_btn_reg[0];
    assign b2      = in_btn_reg[1];
    assign em      = in_btn_reg[2];
    assign any_btn = b1 || b2;

    // Timer increment with saturation; the first press starts the window from zero
    assign tmr_base = (phase_reg == PH_WAIT_PRESS) ? '0 : timer_reg;
    assign tmr_inc  = (tmr_base != TIMER_MAX) ? tmr_base + 1'b1 : tmr_base;

    // Pick the limit that applies to this phase
    always_comb begin
        case (phase_reg)
            PH_RUNNING: limit = cfg.run_ticks;
            PH_ALARM:   limit = 16'(cfg.release_ticks);
            default:    limit = cfg.window_ticks;
        endcase
    end

    assign expire  = (CMP_W'(tmr_inc) >= CMP_W'(limit)) || (tmr_inc == TIMER_MAX);
    assign pre_inc = pre_reg + 8'd1;
    assign ev_base = (events_reg == cfg.alarm_cycle_events) ? 12'd0 : events_reg;

    // Next state for one tick
    always_comb begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        events_next = events_reg;
        pre_next    = pre_reg;
        level_next  = level_reg;
        unique case (phase_reg)
            PH_WAIT_PRESS, PH_WINDOW: begin
                if (phase_reg == PH_WINDOW || any_btn) begin
                    if (b1 && b2) begin
                        phase_next = PH_RUNNING;
                        timer_next = '0;
                    end else if (expire) begin
                        timer_next = '0;
                        if (any_btn) begin
                            phase_next  = PH_ALARM;
                            events_next = '0;
                            pre_next    = '0;
                            level_next  = 1'b0;
                        end else begin
                            phase_next = PH_WAIT_RELEASE;
                        end
                    end else begin
                        phase_next = PH_WINDOW;
                        timer_next = tmr_inc;
                    end
                end
            end
            PH_RUNNING: begin
                if (em || expire) begin
                    timer_next = '0;
                    if (any_btn) begin
                        phase_next  = PH_ALARM;
                        events_next = '0;
                        pre_next    = '0;
                        level_next  = 1'b0;
                    end else begin
                        phase_next = PH_WAIT_RELEASE;
                    end
                end else begin
                    timer_next = tmr_inc;
                end
            end
            PH_ALARM: begin
                // Buzzer prescaler and event counter
                pre_next = pre_inc;
                if (pre_inc >= cfg.buzzer_period_ticks) begin
                    pre_next    = '0;
                    level_next  = (events_reg < cfg.alarm_on_events) ? !level_reg : 1'b0;
                    events_next = ev_base + 12'd1;
                end
                // Release detection
                if (any_btn) begin
                    timer_next = '0;
                end else if (expire) begin
                    phase_next = PH_WAIT_RELEASE;
                    timer_next = '0;
                    level_next = 1'b0;
                end else begin
                    timer_next = tmr_inc;
                end
            end
            default: begin
                phase_next = any_btn ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
            end
        endcase
    end

    // Hold the input beat until it moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_btn_reg <= s_tdata[2:0];
        end
    end

    // Advance controller state once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT_RELEASE;
            timer_reg  <= '0;
            events_reg <= '0;
            pre_reg    <= '0;
            level_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            events_reg <= events_next;
            pre_reg    <= pre_next;
            level_reg  <= level_next;
        end
    end

    // Result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'b000, phase_next,
                             (phase_next == PH_ALARM) && level_next,
                             (phase_next == PH_RUNNING)};
        end
    end

endmodule

>>> src/two_hand_press_controller_top.sv
// An accepted tick beat passes through the input register, then the result register.
// Throughput: one tick per cycle while m_tready is high; the input register and
// the result register each hold a beat, so input is taken while a result waits.
// Reset: synchronous active-low aresetn clears the phase to wait-release,
// timers and buzzer state to zero and loads the register defaults.
module two_hand_press_controller_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [0] first_button, [1] second_button,
                                                  // [2] emergency_button
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [0] motor_on, [1] buzzer_on, [4:2] phase
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [thp_pkg::ADDR_W-1:0] paddr,
    input  logic [thp_pkg::DATA_W-1:0] pwdata,
    output logic [thp_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import thp_pkg::*;

    cfg_t cfg;

    // Configuration registers
    thp_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller datapath
    thp_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
